[src/sccl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the size class free list allocator.
package sccl_pkg;

    localparam int SIZE_W = 19;
    localparam int ADDR_W = 18;
    localparam int LG_W   = 5;
    // A rounded block size is at most two to the power SIZE_W.
    localparam int BS_W   = SIZE_W + 1;

    typedef logic [1:0] status_t;

    localparam status_t ST_LIST  = 2'd0;
    localparam status_t ST_FRESH = 2'd1;
    localparam status_t ST_OOM   = 2'd2;
    localparam status_t ST_FREED = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic            oversize;
        logic [LG_W-1:0] block_lg;
        logic [LG_W-1:0] cls;
    } size_class_t;

endpackage

[src/sccl_req_if.sv]
`timescale 1ns / 1ps
// Request channel: one allocate or free item per handshake.
interface sccl_req_if import sccl_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output opcode, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input opcode, input request_size,
                    input block_address, output ready);

endinterface

[src/sccl_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: one result item per request.
interface sccl_rsp_if import sccl_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_address;
    status_t           status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink   (input valid, input granted_address, input status, output ready);

endinterface

[src/size_class_free_list_allocator.sv]
`timescale 1ns / 1ps
// Segregated free-list allocator. Each request is rounded up to a power-of-two
// block no smaller than MIN_BLOCK_BYTES, and that block size selects a size class
// whose list head sits in a register. A free, an oversize request and an out of
// memory answer finish in the idle state that takes them. A pop from a class list
// also goes through a pop state, since the successor comes back from the
// single-port link memory in the cycle after the read. An allocate that finds its
// list empty takes fresh pages from a bump pointer; when the block is smaller than
// a page, the page is split and the link memory is written one block per cycle,
// until all blocks but the last are linked. The result is posted in an output
// register as soon as it is known; the next item is taken once the link memory
// work of the current one is done and the output register is free or read out.
// The link memory needs no clearing after reset.
module size_class_free_list_allocator import sccl_pkg::*; #(
    parameter int MIN_BLOCK_BYTES = 8,
    parameter int PAGE_BYTES      = 4096,
    parameter int POOL_BYTES      = 262144
) (
    input  logic       clk,
    input  logic       rst_n,
    sccl_req_if.sink   req,
    sccl_rsp_if.source rsp
);

    localparam int LOG_MIN     = $clog2(MIN_BLOCK_BYTES);
    localparam int LOG_PAGE    = $clog2(PAGE_BYTES);
    localparam int LINK_DEPTH  = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int IDX_W       = $clog2(LINK_DEPTH);
    localparam int LINK_W      = $clog2(LINK_DEPTH + 1);
    localparam int TOTAL_PAGES = POOL_BYTES / PAGE_BYTES;
    localparam int PG_W        = $clog2(TOTAL_PAGES + 1);
    localparam int POOL_W      = $clog2(POOL_BYTES + 1);
    localparam int MAX_W       = (POOL_W > BS_W) ? POOL_W : BS_W;
    localparam int W_W         = ((MAX_W > ADDR_W) ? MAX_W : ADDR_W) + 1;
    localparam int TOP_LG      = (SIZE_W + 1 < POOL_W) ? SIZE_W + 1 : POOL_W;
    localparam int NUM_CLASSES = TOP_LG - LOG_MIN;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W       = $clog2(PAGE_BYTES / MIN_BLOCK_BYTES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_POP   = 3'b010,
        S_CARVE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LINK_W-1:0]  heads_reg [NUM_CLASSES];
    logic [PG_W-1:0]    pages_used_reg, pages_used_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    status_t            out_status_reg, out_status_next;

    size_class_t        dec;
    logic [CLS_W-1:0]   cls_idx;
    logic [LINK_W-1:0]  head;
    logic               accept;
    logic               free_ok;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   pop_idx;
    logic [W_W-1:0]     bs_w;
    logic [W_W-1:0]     page_w;
    logic [W_W-1:0]     span_w;
    logic [W_W-1:0]     base_w;
    logic [W_W-1:0]     fresh_w;
    logic               fits;
    logic [IDX_W-1:0]   first_idx;

    logic               head_we;
    logic [CLS_W-1:0]   head_waddr;
    logic [LINK_W-1:0]  head_wdata;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    logic [LINK_W-1:0]  mem_wdata;
    logic [LINK_W-1:0]  mem_rdata;

    sccl_class_dec #(
        .LOG_MIN    (LOG_MIN),
        .POOL_BYTES (POOL_BYTES)
    ) u_dec (
        .size (req.request_size),
        .info (dec)
    );

    sccl_link_ram #(
        .DEPTH  (LINK_DEPTH),
        .IDX_W  (IDX_W),
        .DATA_W (LINK_W)
    ) u_links (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready           = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept              = req.valid && req.ready;
    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_address = out_addr_reg;
    assign rsp.status          = out_status_reg;

    always_comb
    begin
        cls_idx   = dec.cls[CLS_W-1:0];
        head      = (int'(cls_idx) < NUM_CLASSES) ? heads_reg[cls_idx] : '0;
        free_ok   = !dec.oversize && (W_W'(req.block_address) < W_W'(POOL_BYTES));
        free_idx  = IDX_W'(W_W'(req.block_address) >> LOG_MIN);
        pop_idx   = IDX_W'(head - LINK_W'(1));
        bs_w      = W_W'(1) << dec.block_lg;
        page_w    = W_W'(PAGE_BYTES);
        // Blocks and pages are both powers of two, so whole pages span the larger.
        span_w    = (bs_w > page_w) ? bs_w : page_w;
        base_w    = W_W'(pages_used_reg) << LOG_PAGE;
        fits      = (base_w + span_w) <= W_W'(POOL_BYTES);
        fresh_w   = base_w + span_w - bs_w;
        first_idx = IDX_W'(base_w >> LOG_MIN);
    end

    always_comb
    begin
        state_next      = state_reg;
        pages_used_next = pages_used_reg;
        cls_next        = cls_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        head_we         = 1'b0;
        head_waddr      = cls_idx;
        head_wdata      = '0;
        mem_we          = 1'b0;
        mem_addr        = pop_idx;
        mem_wdata       = head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    cls_next       = cls_idx;
                    if (req.opcode == OP_FREE)
                    begin
                        out_status_next = ST_FREED;
                        if (free_ok)
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = free_idx;
                            mem_wdata  = head;
                            head_we    = 1'b1;
                            head_wdata = LINK_W'(free_idx) + LINK_W'(1);
                        end
                    end
                    else if (dec.oversize)
                    begin
                        out_status_next = ST_OOM;
                    end
                    else if (head != '0)
                    begin
                        // The successor arrives from the link memory next cycle.
                        out_status_next = ST_LIST;
                        out_addr_next   = ADDR_W'(W_W'(pop_idx) << LOG_MIN);
                        mem_addr        = pop_idx;
                        state_next      = S_POP;
                    end
                    else if (!fits)
                    begin
                        out_status_next = ST_OOM;
                    end
                    else
                    begin
                        out_status_next = ST_FRESH;
                        out_addr_next   = ADDR_W'(fresh_w);
                        pages_used_next = pages_used_reg + PG_W'(span_w >> LOG_PAGE);
                        if (bs_w < page_w)
                        begin
                            // All blocks but the last go on the list, lowest first.
                            head_we    = 1'b1;
                            head_wdata = LINK_W'(first_idx) + LINK_W'(1);
                            cur_next   = first_idx;
                            step_next  = IDX_W'(bs_w >> LOG_MIN);
                            cnt_next   = CNT_W'((page_w >> dec.block_lg) - W_W'(1));
                            state_next = S_CARVE;
                        end
                    end
                end
            end
            S_POP:
            begin
                head_we    = 1'b1;
                head_waddr = cls_reg;
                head_wdata = mem_rdata;
                state_next = S_IDLE;
            end
            S_CARVE:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = (cnt_reg == CNT_W'(1)) ? '0
                          : LINK_W'(cur_reg) + LINK_W'(step_reg) + LINK_W'(1);
                cur_next  = cur_reg + step_reg;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pages_used_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pages_used_reg <= pages_used_next;
            out_valid_reg  <= out_valid_next;
            if (head_we)
            begin
                heads_reg[head_waddr] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg        <= cls_next;
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule

[src/sccl_class_dec.sv]
`timescale 1ns / 1ps
// Size decoder: rounds a byte size up to a power-of-two block and picks its class.
module sccl_class_dec import sccl_pkg::*; #(
    parameter int LOG_MIN    = 3,
    parameter int POOL_BYTES = 262144
) (
    input  logic [SIZE_W-1:0] size,
    output size_class_t       info
);

    localparam int POOL_W = $clog2(POOL_BYTES + 1);
    localparam int CMP_W  = (BS_W > POOL_W) ? BS_W : POOL_W;

    logic [SIZE_W-1:0] size_m1;
    logic [LG_W-1:0]   lg;
    logic [LG_W-1:0]   blk_lg;
    logic [CMP_W-1:0]  bs;

    always_comb
    begin
        size_m1 = size - SIZE_W'(1);
        lg      = '0;
        // Ceiling log2: one past the highest set bit of size minus one.
        if (size > SIZE_W'(1))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (size_m1[i])
                begin
                    lg = LG_W'(i + 1);
                end
            end
        end
        blk_lg = (lg < LG_W'(LOG_MIN)) ? LG_W'(LOG_MIN) : lg;
        bs     = CMP_W'(1) << blk_lg;

        info.oversize = (bs > CMP_W'(POOL_BYTES));
        info.block_lg = blk_lg;
        info.cls      = blk_lg - LG_W'(LOG_MIN);
    end

endmodule

[src/sccl_link_ram.sv]
`timescale 1ns / 1ps
// Single-port link memory with a registered read port.
module sccl_link_ram #(
    parameter int DEPTH  = 32768,
    parameter int IDX_W  = 15,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[tb/sv/size_class_free_list_allocator_tb.sv]
`timescale 1ns / 1ps
// Testbench for the size class allocator: directed and random requests checked against a predictor.
module size_class_free_list_allocator_tb import sccl_pkg::*; ();

    localparam int MIN_BLOCK_BYTES = 8;
    localparam int PAGE_BYTES      = 4096;
    localparam int POOL_BYTES      = 262144;
    localparam int CLASS_COUNT     = 16;
    localparam int BLOCK_COUNT     = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int PAGE_COUNT      = POOL_BYTES / PAGE_BYTES;
    localparam int RANDOM_ITEMS    = 450;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TAIL_CYCLES     = 600;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } grant_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } held_block_t;

    class alloc_scoreboard;
        int unsigned list_head[CLASS_COUNT];
        int unsigned link_of[BLOCK_COUNT];
        int unsigned pages_taken;
        grant_t      owed[$];
        int          mismatches;

        // Applies one accepted request to the allocator state and queues its answer.
        function grant_t predict_request(logic op, logic [SIZE_W-1:0] size,
                                         logic [ADDR_W-1:0] addr);
            int unsigned blk;
            int unsigned cls;
            int unsigned idx;
            int unsigned npages;
            int unsigned base;
            int unsigned nblk;
            int unsigned step;
            int unsigned first;
            grant_t      g;
            blk = MIN_BLOCK_BYTES;
            cls = 0;
            while (blk < size && blk <= POOL_BYTES)
            begin
                blk = blk << 1;
                cls++;
            end
            g.addr   = '0;
            g.status = ST_FREED;
            if (op == OP_FREE)
            begin
                if (blk <= POOL_BYTES && addr < POOL_BYTES)
                begin
                    idx = addr / MIN_BLOCK_BYTES;
                    link_of[idx]   = list_head[cls];
                    list_head[cls] = idx + 1;
                end
            end
            else if (blk > POOL_BYTES)
                g.status = ST_OOM;
            else if (list_head[cls] != 0)
            begin
                idx            = list_head[cls] - 1;
                g.addr         = ADDR_W'(idx * MIN_BLOCK_BYTES);
                g.status       = ST_LIST;
                list_head[cls] = link_of[idx];
            end
            else
            begin
                npages = (blk - 1) / PAGE_BYTES + 1;
                if (pages_taken + npages > PAGE_COUNT)
                    g.status = ST_OOM;
                else
                begin
                    base         = pages_taken * PAGE_BYTES;
                    pages_taken += npages;
                    nblk         = npages * PAGE_BYTES / blk;
                    step         = blk / MIN_BLOCK_BYTES;
                    // All blocks but the last go on the list, lowest address at the head.
                    if (nblk >= 2)
                    begin
                        first = base / MIN_BLOCK_BYTES;
                        for (int unsigned i = 0; i + 1 < nblk; i++)
                        begin
                            idx          = first + i * step;
                            link_of[idx] = (i + 2 < nblk) ? idx + step + 1 : 0;
                        end
                        list_head[cls] = first + 1;
                    end
                    g.addr   = ADDR_W'(base + (nblk - 1) * blk);
                    g.status = ST_FRESH;
                end
            end
            owed.push_back(g);
            return g;
        endfunction

        function void check_grant(logic [ADDR_W-1:0] addr, status_t status);
            grant_t g;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr=%h status=%0d", addr, status);
                return;
            end
            g = owed.pop_front();
            if (g.addr !== addr || g.status !== status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                             g.addr, g.status, addr, status);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sccl_req_if req ();
    sccl_rsp_if rsp ();

    size_class_free_list_allocator #(
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
        .PAGE_BYTES     (PAGE_BYTES),
        .POOL_BYTES     (POOL_BYTES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    alloc_scoreboard book = new;
    held_block_t     held[$];
    int              rsp_hold = 0;
    bit              steady = 1'b0;
    int              cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 3);
        if (r < 9)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small sizes dominate so that carving stays cheap; a few are large or oversize.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return SIZE_W'($urandom_range(0, 64));
        if (r < 80)
            return SIZE_W'($urandom_range(65, 1024));
        if (r < 93)
            return SIZE_W'($urandom_range(1025, 8192));
        if (r < 98)
            return SIZE_W'($urandom_range(8193, POOL_BYTES));
        return SIZE_W'($urandom_range(POOL_BYTES + 1, (1 << SIZE_W) - 1));
    endfunction

    task automatic offer_request(input logic op, input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr);
        grant_t g;
        req.valid         <= 1'b1;
        req.opcode        <= op;
        req.request_size  <= size;
        req.block_address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        g = book.predict_request(op, size, addr);
        if (op == OP_ALLOC && (g.status == ST_LIST || g.status == ST_FRESH))
            held.push_back('{addr: g.addr, size: size});
    endtask

    task automatic pause_sender(input int cycles);
        req.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (rsp_hold > 0)
            begin
                rsp.ready <= 1'b0;
                rsp_hold--;
            end
            else if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            book.check_grant(rsp.granted_address, rsp.status);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", book.owed.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          k;
        held_block_t victim;
        req.valid         <= 1'b0;
        req.opcode        <= OP_ALLOC;
        req.request_size  <= '0;
        req.block_address <= '0;
        rst_n             <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Minimum class from a zero size, then pops and pushes on that list.
        offer_request(OP_ALLOC, 0, 0);
        offer_request(OP_ALLOC, 8, 0);
        offer_request(OP_ALLOC, 7, '1);
        offer_request(OP_FREE, 1, 0);
        offer_request(OP_FREE, 8, 8);
        offer_request(OP_ALLOC, 3, 0);
        // Oversize requests: allocate fails, free is ignored.
        offer_request(OP_ALLOC, '1, 0);
        offer_request(OP_ALLOC, SIZE_W'(POOL_BYTES + 1), 0);
        offer_request(OP_FREE, SIZE_W'(POOL_BYTES + 1), 40);
        // Misaligned free at the top of the pool comes back rounded down.
        offer_request(OP_FREE, 8, '1);
        offer_request(OP_ALLOC, 8, 0);
        // Whole pool no longer fits.
        offer_request(OP_ALLOC, SIZE_W'(POOL_BYTES), 0);
        // Multi-page and exact-page grants.
        offer_request(OP_ALLOC, SIZE_W'(POOL_BYTES / 2), 0);
        offer_request(OP_ALLOC, SIZE_W'(PAGE_BYTES), 0);
        offer_request(OP_ALLOC, SIZE_W'(PAGE_BYTES + 1), 0);
        offer_request(OP_ALLOC, 2048, 0);
        // Misaligned free into the wrong class.
        offer_request(OP_FREE, 2048, 12);
        offer_request(OP_ALLOC, 2000, 0);
        // Block that sits on the minimum class list freed into another class.
        offer_request(OP_FREE, 64, 16);
        offer_request(OP_ALLOC, 33, 0);
        // Double free of the same block.
        offer_request(OP_FREE, 32768, 196608);
        offer_request(OP_FREE, 32768, 196608);
        offer_request(OP_ALLOC, 32768, 0);
        offer_request(OP_ALLOC, 20000, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 200 && n < 260);
            // Long receiver hold-off while the sender keeps offering items.
            if (n == 120)
                rsp_hold = 300;
            // Sender waits until every outstanding result has been seen.
            if (n == 330)
            begin
                req.valid <= 1'b0;
                do
                    @(posedge clk);
                while (book.owed.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 50 || held.size() == 0)
                offer_request(OP_ALLOC, pick_size(), ADDR_W'($urandom()));
            else if (r < 93)
            begin
                k      = $urandom_range(0, held.size() - 1);
                victim = held[k];
                held.delete(k);
                offer_request(OP_FREE, victim.size, victim.addr);
            end
            else
                offer_request(OP_FREE, pick_size(), ADDR_W'($urandom()));
            if (!steady && $urandom_range(0, 2) == 0)
                pause_sender(gap_len());
        end

        req.valid <= 1'b0;
        steady = 1'b0;
        do
            @(posedge clk);
        while (book.owed.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (book.mismatches == 0 && book.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
src/sccl_pkg.sv
src/sccl_req_if.sv
src/sccl_rsp_if.sv
src/sccl_class_dec.sv
src/sccl_link_ram.sv
src/size_class_free_list_allocator.sv
tb/sv/size_class_free_list_allocator_tb.sv
